/* design/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Operation and status codes, word width and the per-cycle cell command.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEQ_DEPTH = 16;
  localparam int WORD_W    = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } deq_op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_t;

  // Command broadcast to every cell in the same cycle.
  typedef struct packed {
    logic                     add_front;
    logic                     add_back;
    logic                     take_front;
    logic                     take_back;
    logic signed [WORD_W-1:0] word;
  } cell_ctrl_t;

endpackage

/* design/deq_cell.sv */
// ----------------------------------------------------------------------------
// deq_cell: one storage cell of the queue row
// Holds one word and a valid bit; shifts with its neighbors on front
// operations and fills or drains itself when it sits at the back.
// ----------------------------------------------------------------------------
module deq_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  deq_pkg::cell_ctrl_t               ctrl,
  input  logic                              left_valid,
  input  logic signed [deq_pkg::WORD_W-1:0] left_data,
  input  logic                              right_valid,
  input  logic signed [deq_pkg::WORD_W-1:0] right_data,
  output logic                              valid,
  output logic signed [deq_pkg::WORD_W-1:0] data,
  output logic signed [deq_pkg::WORD_W-1:0] back_data
);
  import deq_pkg::*;

  logic                     valid_r, valid_nxt;
  logic signed [WORD_W-1:0] data_r, data_nxt;
  logic                     is_last;
  logic                     is_free_tail;

  assign is_last      = valid_r && !right_valid;
  assign is_free_tail = left_valid && !valid_r;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctrl.add_front) begin
      valid_nxt = left_valid;
      data_nxt  = left_data;
    end else if (ctrl.take_front) begin
      valid_nxt = right_valid;
      data_nxt  = right_data;
    end else if (ctrl.add_back && is_free_tail) begin
      valid_nxt = 1'b1;
      data_nxt  = ctrl.word;
    end else if (ctrl.take_back && is_last) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid     = valid_r;
  assign data      = data_r;
  assign back_data = is_last ? data_r : '0;

endmodule

/* design/double_ended_queue_unit.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_unit: bounded double-ended queue of signed words
// A row of DEPTH cells with the front at cell 0; front operations shift
// the whole row, back operations touch only the first free or last valid cell.
// The result is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle while the result output is not stalled; the row updates in one step per item.
// Reset: synchronous active-low clears all valid bits, count and output valid.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_func,
  input  logic signed [deq_pkg::WORD_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [deq_pkg::WORD_W-1:0] out_popped,
  output logic [1:0]                        out_status,
  output logic [CNT_W-1:0]                  out_occupancy
);
  import deq_pkg::*;

  logic [DEPTH-1:0]         valid_vec;
  logic signed [WORD_W-1:0] data_arr [DEPTH];
  logic signed [WORD_W-1:0] back_arr [DEPTH];
  logic signed [WORD_W-1:0] back_word;
  cell_ctrl_t               ctrl;

  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r;
  logic signed [WORD_W-1:0] popped_r, popped_nxt;
  deq_status_t              status_r, status_nxt;
  logic [CNT_W-1:0]         occ_r;

  deq_op_t op;
  logic    accept;
  logic    full;
  logic    empty;

  assign op       = deq_op_t'(in_func);
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = valid_vec[DEPTH-1];
  assign empty    = !valid_vec[0];

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic                     lv, rv;
      logic signed [WORD_W-1:0] ld, rd;
      if (g == 0) begin : g_first
        assign lv = 1'b1;
        assign ld = in_value;
      end else begin : g_mid
        assign lv = valid_vec[g-1];
        assign ld = data_arr[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign rv = 1'b0;
        assign rd = '0;
      end else begin : g_body
        assign rv = valid_vec[g+1];
        assign rd = data_arr[g+1];
      end
      deq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .left_valid  (lv),
        .left_data   (ld),
        .right_valid (rv),
        .right_data  (rd),
        .valid       (valid_vec[g]),
        .data        (data_arr[g]),
        .back_data   (back_arr[g])
      );
    end
  endgenerate

  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | back_arr[i];
    end
  end

  always_comb begin
    ctrl       = '0;
    ctrl.word  = in_value;
    popped_nxt = '0;
    status_nxt = ST_DONE;
    cnt_nxt    = cnt_r;
    unique case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.add_front = accept && (op == OP_PUSH_FRONT);
          ctrl.add_back  = accept && (op == OP_PUSH_BACK);
          cnt_nxt        = cnt_r + CNT_W'(1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) begin
          popped_nxt = '1;
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.take_front = accept && (op == OP_POP_FRONT);
          ctrl.take_back  = accept && (op == OP_POP_BACK);
          popped_nxt      = (op == OP_POP_FRONT) ? data_arr[0] : back_word;
          cnt_nxt         = cnt_r - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
      occ_r    <= cnt_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_popped    = popped_r;
  assign out_status    = status_r;
  assign out_occupancy = occ_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(cnt_r))
    else $error("entry count disagrees with cell valid bits");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + DEPTH'(1)) & valid_vec) == '0)
    else $error("cell valid bits not a contiguous prefix");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    accept && full && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
    |=> $stable(cnt_r) && status_r == ST_FULL)
    else $error("push on full queue changed the count");

  a_empty_popped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_EMPTY |-> popped_r == '1 && occ_r == '0)
    else $error("empty pop result malformed");

endmodule

/* sim/tb_double_ended_queue_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_unit: self-checking bench for the double-ended queue
// Drives push and pop items at both ends, keeps a shadow deque of the block
// and checks every result item field by field, in order, with and without random stalls.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_unit;
  import deq_pkg::*;

  localparam int OCC_W     = $clog2(DEQ_DEPTH + 1);
  localparam int MAX_SHOWN = 10;

  typedef struct {
    logic signed [WORD_W-1:0] popped;
    deq_status_t              status;
    logic [OCC_W-1:0]         occupancy;
  } deq_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               in_func;
  logic signed [WORD_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [WORD_W-1:0] out_popped;
  logic [1:0]               out_status;
  logic [OCC_W-1:0]         out_occupancy;

  logic [WORD_W-1:0] shadow_slots [DEQ_DEPTH];
  int                shadow_front;
  int                shadow_count;
  deq_result_t       pending_results [$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int stray_count;

  double_ended_queue_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_popped    (out_popped),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void apply_deque_op(input deq_op_t op, input logic [WORD_W-1:0] word);
    deq_result_t res;
    int          pos;
    res.popped = '0;
    res.status = ST_DONE;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count >= DEQ_DEPTH) begin
          res.status = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          shadow_front = (shadow_front + DEQ_DEPTH - 1) % DEQ_DEPTH;
          shadow_slots[shadow_front] = word;
          shadow_count++;
        end else begin
          pos = (shadow_front + shadow_count) % DEQ_DEPTH;
          shadow_slots[pos] = word;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          res.popped = '1;
          res.status = ST_EMPTY;
        end else if (op == OP_POP_FRONT) begin
          res.popped = shadow_slots[shadow_front];
          shadow_front = (shadow_front + 1) % DEQ_DEPTH;
          shadow_count--;
        end else begin
          pos = (shadow_front + shadow_count - 1) % DEQ_DEPTH;
          res.popped = shadow_slots[pos];
          shadow_count--;
        end
      end
    endcase
    res.occupancy = shadow_count[OCC_W-1:0];
    pending_results.insert(pending_results.size(), res);
  endfunction

  task automatic send_item(input deq_op_t op, input logic [WORD_W-1:0] word);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_func  = op;
    in_value = word;
    do @(posedge clk); while (!in_ready);
    apply_deque_op(op, word);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      4:       return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random_ops(input int n_items);
    int      push_bias;
    deq_op_t op;
    push_bias = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 24 == 0) begin
        case ($urandom_range(3))
          0:       push_bias = 88;
          1:       push_bias = 12;
          2:       push_bias = 50;
          default: push_bias = $urandom_range(100);
        endcase
      end
      if ($urandom_range(99) < push_bias)
        op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else
        op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
      send_item(op, pick_word());
    end
  endtask

  task automatic test_directed_edges();
    send_item(OP_POP_FRONT, 32'h1234_5678);
    send_item(OP_POP_BACK, 32'hffff_ffff);
    for (int i = 0; i < DEQ_DEPTH; i++) begin
      case (i % 4)
        0: send_item(OP_PUSH_FRONT, 32'h7fff_ffff - i);
        1: send_item(OP_PUSH_BACK, 32'h8000_0000 + i);
        2: send_item(OP_PUSH_FRONT, 32'hffff_ffff);
        3: send_item(OP_PUSH_BACK, 32'(i));
      endcase
    end
    send_item(OP_PUSH_FRONT, 32'h5555_5555);
    send_item(OP_PUSH_BACK, 32'haaaa_aaaa);
    send_item(OP_POP_FRONT, 32'h0);
    send_item(OP_POP_BACK, 32'h0);
    send_item(OP_POP_BACK, 32'hffff_ffff);
    send_item(OP_POP_FRONT, 32'h0);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 18;
    recv_idle_pct = 63;
    run_random_ops(230);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 63;
    recv_idle_pct = 18;
    run_random_ops(230);
  endtask

  task automatic test_back_to_back();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_ops(230);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    deq_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        stray_count++;
        if (mismatch_count + stray_count <= MAX_SHOWN)
          $display("%0t: result item with nothing pending: popped %0d status %0d occ %0d",
                   $realtime, out_popped, out_status, out_occupancy);
      end else begin
        exp_res = pending_results[0];
        pending_results.delete(0);
        if (out_popped !== exp_res.popped || out_status !== exp_res.status ||
            out_occupancy !== exp_res.occupancy) begin
          mismatch_count++;
          if (mismatch_count + stray_count <= MAX_SHOWN)
            $display("%0t: mismatch: exp popped %0d status %0d occ %0d, got %0d %0d %0d",
                     $realtime, exp_res.popped, exp_res.status, exp_res.occupancy,
                     out_popped, out_status, out_occupancy);
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = OP_PUSH_FRONT;
    in_value       = '0;
    send_idle_pct  = 18;
    recv_idle_pct  = 63;
    mismatch_count = 0;
    stray_count    = 0;
    shadow_front   = 0;
    shadow_count   = 0;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_edges();
    test_receiver_stalls();
    test_sender_gaps();
    test_back_to_back();

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatch_count == 0 && stray_count == 0 && pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
